// ===== sv/ile_pkg.sv =====
// ----------------------------------------------------------------------------
// ile_pkg: shared types and constants for the indexed list engine
// Command and status codes, transfer payload structs and the control word
// that the top level broadcasts along the row of storage cells.
// ----------------------------------------------------------------------------
package ile_pkg;

    // List geometry
    localparam int DEPTH  = 16;
    localparam int WIDTH  = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int POS_W  = 5;
    localparam int CNT_W  = 5;

    // Command codes; the two unused codes fall to the default arm
    typedef enum logic [2:0] {
        CMD_APPEND = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_ERASE  = 3'd3,
        CMD_READ   = 3'd4,
        CMD_CLEAR  = 3'd5
    } cmd_e;

    // Status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_e;

    // Request transfer
    typedef struct packed {
        logic [2:0]       cmd;
        logic [POS_W-1:0] position;
        logic [31:0]      value;
    } req_t;

    // Response transfer
    typedef struct packed {
        logic [31:0]      read_value;
        logic [CNT_W-1:0] entry_count;
        logic [1:0]       status;
    } rsp_t;

    // Broadcast to every cell; at most one of ins/app/ers is set
    typedef struct packed {
        logic             ins;
        logic             app;
        logic             ers;
        logic [POS_W-1:0] pos;
        logic [CNT_W-1:0] cnt;
        logic [WIDTH-1:0] word;
    } ctrl_t;

endpackage

// ===== sv/ile_cell.sv =====
// ----------------------------------------------------------------------------
// ile_cell: one storage slot of the list
// Holds a single entry and, on command, loads the new word, takes its lower
// neighbour's entry (insert shift) or its upper neighbour's entry (erase).
// ----------------------------------------------------------------------------
module ile_cell (
    input  logic                    clk,
    input  ile_pkg::ctrl_t          ctrl,
    input  logic [ile_pkg::POS_W-1:0] idx,
    input  logic [ile_pkg::WIDTH-1:0] lower,
    input  logic [ile_pkg::WIDTH-1:0] upper,
    output logic [ile_pkg::WIDTH-1:0] data
);

    logic [ile_pkg::WIDTH-1:0] data_reg;
    logic [ile_pkg::WIDTH-1:0] data_next;
    logic [ile_pkg::POS_W:0]   idx_p1;

    assign idx_p1 = {1'b0, idx} + {{ile_pkg::POS_W{1'b0}}, 1'b1};

    // Slot update selection
    always_comb
    begin
        data_next = data_reg;
        priority if (ctrl.ins && idx == ctrl.pos)
        begin
            data_next = ctrl.word;
        end
        else if (ctrl.ins && idx > ctrl.pos && idx <= ctrl.cnt)
        begin
            data_next = lower;
        end
        else if (ctrl.app && idx == ctrl.cnt)
        begin
            data_next = ctrl.word;
        end
        else if (ctrl.ers && idx >= ctrl.pos && idx_p1 < {1'b0, ctrl.cnt})
        begin
            data_next = upper;
        end
        else
        begin
            // slot untouched by this command
            data_next = data_reg;
        end
    end

    // Payload only: no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== sv/indexed_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// indexed_list_engine_top: fixed-capacity ordered list of words
// Append, remove tail, insert, erase, read and clear over a row of cells
// that shift all entries together; one response per request.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req  (cmd, position, value)
//  rsp     | out       | rsp_valid/rsp_ready  | rsp  (read_value, entry_count,
//          |           |                      |       status)
//
// One request per cycle unless the response stalls; its response is registered
// and appears the cycle after the transfer. The whole row of cells shifts
// together, so insert and erase cost the same as append. Reset clears the
// count and the response valid flag; entry contents are not reset. A stalled
// response holds the next request back only while it is itself not taken.
// ----------------------------------------------------------------------------
module indexed_list_engine_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ile_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ile_pkg::rsp_t rsp
);

    logic [ile_pkg::CNT_W-1:0] count_reg;
    logic [ile_pkg::CNT_W-1:0] count_next;
    logic                      rsp_valid_reg;
    logic                      rsp_valid_next;
    ile_pkg::rsp_t             rsp_reg;
    ile_pkg::rsp_t             rsp_next;
    ile_pkg::ctrl_t            ctrl;
    ile_pkg::status_e          status;
    logic [31:0]               read_word;
    logic                      req_fire;
    logic                      is_full;
    logic                      is_empty;
    logic [ile_pkg::WIDTH-1:0] cell_data [ile_pkg::DEPTH];

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign req_fire  = req_valid && req_ready;
    assign is_full   = count_reg >= ile_pkg::CNT_W'(ile_pkg::DEPTH);
    assign is_empty  = count_reg == '0;

    // Command decode: status, new count and cell control
    always_comb
    begin
        status     = ile_pkg::ST_OK;
        count_next = count_reg;
        ctrl       = '0;
        ctrl.pos   = req.position;
        ctrl.cnt   = count_reg;
        ctrl.word  = req.value[ile_pkg::WIDTH-1:0];
        read_word  = '0;
        unique case (ile_pkg::cmd_e'(req.cmd))
            ile_pkg::CMD_APPEND:
            begin
                if (is_full)
                begin
                    status = ile_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.app   = req_fire;
                    count_next = count_reg + 1'b1;
                end
            end
            ile_pkg::CMD_REMOVE:
            begin
                if (is_empty)
                begin
                    status = ile_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            ile_pkg::CMD_INSERT:
            begin
                if (is_full)
                begin
                    status = ile_pkg::ST_FULL;
                end
                else if (req.position > count_reg)
                begin
                    status = ile_pkg::ST_RANGE;
                end
                else
                begin
                    ctrl.ins   = req_fire;
                    count_next = count_reg + 1'b1;
                end
            end
            ile_pkg::CMD_ERASE:
            begin
                if (is_empty)
                begin
                    status = ile_pkg::ST_EMPTY;
                end
                else if (req.position >= count_reg)
                begin
                    status = ile_pkg::ST_RANGE;
                end
                else
                begin
                    ctrl.ers   = req_fire;
                    count_next = count_reg - 1'b1;
                end
            end
            ile_pkg::CMD_READ:
            begin
                if (req.position >= count_reg)
                begin
                    status = ile_pkg::ST_RANGE;
                end
                else
                begin
                    read_word = 32'(cell_data[req.position[ile_pkg::IDX_W-1:0]]);
                end
            end
            ile_pkg::CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    // Row of storage cells
    for (genvar g = 0; g < ile_pkg::DEPTH; g++)
    begin : g_cell
        logic [ile_pkg::WIDTH-1:0] lower;
        logic [ile_pkg::WIDTH-1:0] upper;
        if (g == 0)
        begin : g_first
            assign lower = '0;
        end
        else
        begin : g_mid_lo
            assign lower = cell_data[g-1];
        end
        if (g == ile_pkg::DEPTH - 1)
        begin : g_last
            assign upper = '0;
        end
        else
        begin : g_mid_hi
            assign upper = cell_data[g+1];
        end
        ile_cell u_cell (
            .clk   (clk),
            .ctrl  (ctrl),
            .idx   (ile_pkg::POS_W'(g)),
            .lower (lower),
            .upper (upper),
            .data  (cell_data[g])
        );
    end

    // Response register next values
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        if (req_fire)
        begin
            rsp_valid_next       = 1'b1;
            rsp_next.read_value  = read_word;
            rsp_next.entry_count = count_next;
            rsp_next.status      = status;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (req_fire)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ile_pkg::CNT_W'(ile_pkg::DEPTH))
        else $error("list count above capacity");

    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> rsp_valid_reg && rsp_reg.entry_count == count_reg)
        else $error("response missing or count mismatch after transfer");

    a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && req.cmd != ile_pkg::CMD_READ |=> rsp_reg.read_value == '0)
        else $error("non-read response carries data");

    a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status == ile_pkg::ST_FULL
        |-> rsp_reg.entry_count == ile_pkg::CNT_W'(ile_pkg::DEPTH))
        else $error("full status while list not full");
`endif

endmodule
